/* hw/rtl/uer_pkg.sv */
// shared types and constants of the ultrasonic echo ranger
`timescale 1ns / 1ps

package uer_pkg;

  localparam int unsigned TEMP_W        = 15;
  localparam int unsigned CNT_W         = 17;
  localparam int unsigned DIST_W        = 18;
  localparam int unsigned ROOT_IN_W     = 16;
  localparam int unsigned ACC_W         = 24;
  localparam int unsigned STEP_W        = 5;

  localparam int unsigned TRIGGER_TICKS = 15;
  localparam int unsigned TIMEOUT_TICKS = 100000;

  localparam int unsigned TEMP_RESET    = 2000;
  localparam int unsigned TEMP_OFFSET   = 27315;
  localparam int unsigned VEL_SCALE     = 51328;
  localparam int unsigned VEL_ROUND     = 50;
  localparam int unsigned VEL_DIV       = 100;
  localparam int unsigned DIST_ROUND    = 25600;
  localparam int unsigned DIST_SHIFT    = 11;
  localparam int unsigned DIST_DIV      = 25;
  localparam int unsigned SQRT_STEPS    = 8;
  localparam int unsigned SQRT_TOP      = 1 << 14;
  localparam int unsigned VEL_QBITS     = 17;
  localparam int unsigned DIST_QBITS    = 18;

  localparam logic [CNT_W-1:0]     TRIG_TICKS_C  = CNT_W'(TRIGGER_TICKS);
  localparam logic [CNT_W-1:0]     TIMEOUT_C     = CNT_W'(TIMEOUT_TICKS);
  localparam logic [TEMP_W-1:0]    TEMP_RESET_C  = TEMP_W'(TEMP_RESET);
  localparam logic [CNT_W-1:0]     TEMP_OFFSET_C = CNT_W'(TEMP_OFFSET);
  localparam logic [ACC_W-1:0]     VEL_SCALE_C   = ACC_W'(VEL_SCALE);
  localparam logic [ACC_W-1:0]     VEL_ROUND_C   = ACC_W'(VEL_ROUND);
  localparam logic [ACC_W-1:0]     VEL_DEN_TOP_C = ACC_W'(VEL_DIV << (VEL_QBITS - 1));
  localparam logic [2*CNT_W-1:0]   DIST_ROUND_C  = (2*CNT_W)'(DIST_ROUND);
  localparam logic [ACC_W-1:0]     DIST_SAT_C    = ACC_W'(DIST_DIV << DIST_QBITS);
  localparam logic [ACC_W-1:0]     DIST_DEN_TOP_C = ACC_W'(DIST_DIV << (DIST_QBITS - 1));
  localparam logic [ACC_W-1:0]     SQRT_TOP_C    = ACC_W'(SQRT_TOP);
  localparam logic [STEP_W-1:0]    SQRT_LAST_C   = STEP_W'(SQRT_STEPS - 1);
  localparam logic [STEP_W-1:0]    VEL_LAST_C    = STEP_W'(VEL_QBITS - 1);
  localparam logic [STEP_W-1:0]    DIST_LAST_C   = STEP_W'(DIST_QBITS - 1);

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_ECHO_HIGH = 2'd1,
    ERR_NO_RISE   = 2'd2,
    ERR_NO_FALL   = 2'd3
  } err_e;

  typedef struct packed {
    logic trig;
    logic busy;
    logic done;
    err_e err;
    logic vel_start;
    logic dist_start;
  } phase_res_t;

  typedef struct packed {
    logic vel;
    logic dst;
  } arith_req_t;

endpackage

/* hw/rtl/uer_arith.sv */
// shared compare-subtract unit for square root, velocity and distance
`timescale 1ns / 1ps

module uer_arith (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  uer_pkg::arith_req_t                req_i,
  input  logic [uer_pkg::ROOT_IN_W-1:0]      tk_i,
  input  logic [uer_pkg::CNT_W-1:0]          vel_i,
  input  logic [uer_pkg::CNT_W-1:0]          pw_i,
  output logic                               done_o,
  output logic [uer_pkg::DIST_W-1:0]         result_o
);
  import uer_pkg::*;

  typedef enum logic [5:0] {
    AS_IDLE = 6'b000001,
    AS_SQRT = 6'b000010,
    AS_VMUL = 6'b000100,
    AS_DMUL = 6'b001000,
    AS_DCHK = 6'b010000,
    AS_DIV  = 6'b100000
  } arith_state_e;

  arith_state_e        st_q, st_d;
  logic [ACC_W-1:0]    rem_q, rem_d;
  logic [ACC_W-1:0]    opd_q, opd_d;
  logic [DIST_W-1:0]   res_q, res_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic                done_q, done_d;

  logic [ACC_W-1:0]    operand;
  logic [ACC_W:0]      diff;
  logic                ge;
  logic [ACC_W-1:0]    vmul;
  logic [2*CNT_W-1:0]  dprod;
  logic [2*CNT_W-1:0]  dsum;

  // sqrt compares against root + bit, division against the shifted divisor
  assign operand = (st_q == AS_SQRT) ? (opd_q + {{(ACC_W-DIST_W){1'b0}}, res_q}) : opd_q;
  assign diff    = {1'b0, rem_q} - {1'b0, operand};
  assign ge      = ~diff[ACC_W];

  assign vmul  = {{(ACC_W-8){1'b0}}, res_q[7:0]} * VEL_SCALE_C;
  assign dprod = {{CNT_W{1'b0}}, vel_i} * {{CNT_W{1'b0}}, pw_i};
  assign dsum  = dprod + DIST_ROUND_C;

  always_comb begin
    st_d   = st_q;
    rem_d  = rem_q;
    opd_d  = opd_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    case (st_q)
      AS_IDLE: begin
        if (req_i.vel) begin
          rem_d = {{(ACC_W-ROOT_IN_W){1'b0}}, tk_i};
          opd_d = SQRT_TOP_C;
          res_d = '0;
          cnt_d = SQRT_LAST_C;
          st_d  = AS_SQRT;
        end else if (req_i.dst) begin
          st_d = AS_DMUL;
        end
      end
      AS_SQRT: begin
        if (ge) begin
          rem_d = diff[ACC_W-1:0];
          res_d = (res_q >> 1) + opd_q[DIST_W-1:0];
        end else begin
          res_d = res_q >> 1;
        end
        opd_d = opd_q >> 2;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d = AS_VMUL;
        end
      end
      AS_VMUL: begin
        rem_d = vmul + VEL_ROUND_C;
        opd_d = VEL_DEN_TOP_C;
        res_d = '0;
        cnt_d = VEL_LAST_C;
        st_d  = AS_DIV;
      end
      AS_DMUL: begin
        rem_d = {1'b0, dsum[2*CNT_W-1:DIST_SHIFT]};
        opd_d = DIST_SAT_C;
        st_d  = AS_DCHK;
      end
      AS_DCHK: begin
        if (ge) begin
          res_d  = '1;
          done_d = 1'b1;
          st_d   = AS_IDLE;
        end else begin
          opd_d = DIST_DEN_TOP_C;
          res_d = '0;
          cnt_d = DIST_LAST_C;
          st_d  = AS_DIV;
        end
      end
      AS_DIV: begin
        if (ge) begin
          rem_d = diff[ACC_W-1:0];
        end
        res_d = {res_q[DIST_W-2:0], ge};
        opd_d = opd_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d = 1'b1;
          st_d   = AS_IDLE;
        end
      end
      default: begin
        st_d = AS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= AS_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    opd_q <= opd_d;
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* hw/rtl/uer_phase.sv */
// measurement phase sequencer: trigger pulse, echo wait and pulse timing
`timescale 1ns / 1ps

module uer_phase (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       start_i,
  input  logic                       echo_i,
  output uer_pkg::phase_res_t        res_o,
  output logic [uer_pkg::CNT_W-1:0]  pulse_width_o
);
  import uer_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_TRIG_LOW  = 5'b00010,
    PH_TRIG_HIGH = 5'b00100,
    PH_WAIT_RISE = 5'b01000,
    PH_WAIT_FALL = 5'b10000
  } phase_e;

  phase_e            ph_q, ph_d;
  logic [CNT_W-1:0]  tick_q, tick_d;
  logic [CNT_W-1:0]  pw_q, pw_d;
  logic [CNT_W-1:0]  tick_inc;
  logic [CNT_W-1:0]  pw_inc;
  phase_res_t        res;

  assign tick_inc = tick_q + 1'b1;
  assign pw_inc   = pw_q + 1'b1;

  always_comb begin
    ph_d           = ph_q;
    tick_d         = tick_q;
    pw_d           = pw_q;
    res.trig       = 1'b0;
    res.done       = 1'b0;
    res.err        = ERR_NONE;
    res.vel_start  = 1'b0;
    res.dist_start = 1'b0;
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          if (echo_i) begin
            res.done = 1'b1;
            res.err  = ERR_ECHO_HIGH;
          end else begin
            res.vel_start = 1'b1;
            ph_d          = PH_TRIG_LOW;
            tick_d        = CNT_W'(1);
            pw_d          = '0;
          end
        end
      end
      PH_TRIG_LOW: begin
        if (tick_q >= TRIG_TICKS_C) begin
          ph_d     = PH_TRIG_HIGH;
          tick_d   = CNT_W'(1);
          res.trig = 1'b1;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_TRIG_HIGH: begin
        if (tick_q >= TRIG_TICKS_C) begin
          ph_d   = PH_WAIT_RISE;
          tick_d = '0;
        end else begin
          tick_d   = tick_inc;
          res.trig = 1'b1;
        end
      end
      PH_WAIT_RISE: begin
        if (echo_i) begin
          ph_d = PH_WAIT_FALL;
          pw_d = CNT_W'(1);
        end else begin
          tick_d = tick_inc;
          if (tick_inc >= TIMEOUT_C) begin
            ph_d     = PH_IDLE;
            res.done = 1'b1;
            res.err  = ERR_NO_RISE;
          end
        end
      end
      PH_WAIT_FALL: begin
        if (!echo_i) begin
          ph_d           = PH_IDLE;
          res.done       = 1'b1;
          res.dist_start = 1'b1;
        end else begin
          pw_d = pw_inc;
          if (pw_inc >= TIMEOUT_C) begin
            ph_d     = PH_IDLE;
            res.done = 1'b1;
            res.err  = ERR_NO_FALL;
          end
        end
      end
      default: begin
        ph_d = PH_IDLE;
      end
    endcase
    res.busy = (ph_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      tick_q <= '0;
      pw_q   <= '0;
    end else if (accept_i) begin
      ph_q   <= ph_d;
      tick_q <= tick_d;
      pw_q   <= pw_d;
    end
  end

  assign res_o         = res;
  assign pulse_width_o = pw_q;

endmodule

/* hw/rtl/ultrasonic_echo_ranger.sv */
// top level of the ultrasonic echo ranger
`timescale 1ns / 1ps

// Each request is one 1 us tick (start request and sampled echo level) and
// gives exactly one response with the trigger level, busy, done, error code
// and distance in 0.1 mm units. Most ticks hold the input off only while a
// response waits on out_ready_i. The tick that starts a measurement latches
// the temperature and then holds the input off while the shared
// compare-subtract unit takes the square root (8 steps), multiplies (1 step)
// and divides by 100 (17 steps); its response is ready at once. The echo
// falling-edge tick holds the input off for one multiply, a saturation check
// and 18 divide steps on the same unit (no divide steps when the distance
// saturates), and its response follows them. The temperature register is
// written with cfg_we_i and applies at the next start.
module ultrasonic_echo_ranger (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic signed [uer_pkg::TEMP_W-1:0] cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              start_req_i,
  input  logic                              echo_level_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              trigger_out_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic [1:0]                        error_code_o,
  output logic [uer_pkg::DIST_W-1:0]        distance_o
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_VEL  = 3'b010,
    ST_DIST = 3'b100
  } seq_e;

  seq_e                 seq_q, seq_d;
  logic [TEMP_W-1:0]    temp_q;
  logic [CNT_W-1:0]     vel_q, vel_d;
  logic                 oval_q, oval_d;
  logic                 trig_q, trig_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  err_e                 err_q, err_d;
  logic [DIST_W-1:0]    dist_q, dist_d;

  logic                 accept;
  logic                 out_free;
  phase_res_t           ph_res;
  logic [CNT_W-1:0]     pulse_width;
  logic [CNT_W-1:0]     tsum;
  arith_req_t           areq;
  logic                 adone;
  logic [DIST_W-1:0]    aresult;

  assign out_free   = ~oval_q | out_ready_i;
  assign in_ready_o = (seq_q == ST_IDLE) & out_free;
  assign accept     = in_valid_i & in_ready_o;

  // temperature plus offset in hundredths of a kelvin, always positive
  assign tsum = {{(CNT_W-TEMP_W){temp_q[TEMP_W-1]}}, temp_q} + TEMP_OFFSET_C;

  assign areq.vel = accept & ph_res.vel_start;
  assign areq.dst = accept & ph_res.dist_start;

  uer_phase u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .start_i       (start_req_i),
    .echo_i        (echo_level_i),
    .res_o         (ph_res),
    .pulse_width_o (pulse_width)
  );

  uer_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (areq),
    .tk_i     (tsum[ROOT_IN_W-1:0]),
    .vel_i    (vel_q),
    .pw_i     (pulse_width),
    .done_o   (adone),
    .result_o (aresult)
  );

  always_comb begin
    seq_d  = seq_q;
    vel_d  = vel_q;
    oval_d = oval_q & ~out_ready_i;
    trig_d = trig_q;
    busy_d = busy_q;
    done_d = done_q;
    err_d  = err_q;
    dist_d = dist_q;
    case (seq_q)
      ST_IDLE: begin
        if (accept) begin
          if (ph_res.dist_start) begin
            seq_d = ST_DIST;
          end else begin
            oval_d = 1'b1;
            trig_d = ph_res.trig;
            busy_d = ph_res.busy;
            done_d = ph_res.done;
            err_d  = ph_res.err;
            dist_d = '0;
            if (ph_res.vel_start) begin
              seq_d = ST_VEL;
            end
          end
        end
      end
      ST_VEL: begin
        if (adone) begin
          vel_d = aresult[CNT_W-1:0];
          seq_d = ST_IDLE;
        end
      end
      ST_DIST: begin
        if (adone) begin
          oval_d = 1'b1;
          trig_d = 1'b0;
          busy_d = 1'b0;
          done_d = 1'b1;
          err_d  = ERR_NONE;
          dist_d = aresult;
          seq_d  = ST_IDLE;
        end
      end
      default: begin
        seq_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= ST_IDLE;
      temp_q <= TEMP_RESET_C;
      vel_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      seq_q  <= seq_d;
      vel_q  <= vel_d;
      oval_q <= oval_d;
      if (cfg_we_i) begin
        temp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
    busy_q <= busy_d;
    done_q <= done_d;
    err_q  <= err_d;
    dist_q <= dist_d;
  end

  assign out_valid_o   = oval_q;
  assign trigger_out_o = trig_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;
  assign error_code_o  = err_q;
  assign distance_o    = dist_q;

endmodule
